// ----- src/pcbe_pkg.sv -----
// Shared types and constants for the piecewise cubic Bezier evaluator.
package pcbe_pkg;

  // Fixed field widths of the command and result words.
  localparam int unsigned PORT_W     = 32;
  localparam int unsigned SEG_W      = 4;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned S_W        = 17;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROD_W     = S_W + CNT_W;
  localparam int unsigned IR_W       = PROD_W - FRAC_W;
  localparam int unsigned NPTS       = 4;
  localparam int unsigned ONE_Q16    = 65536;
  localparam int          HALF_LSB   = 32768;
  localparam int          D1_GAIN    = 3;
  localparam int          D2_GAIN    = 6;

  // Curvature datapath widths.
  localparam int unsigned CURV_W     = 31;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DEN_W      = 96;
  localparam int unsigned REM_W      = 128;
  localparam int unsigned QUO_BITS   = 31;
  localparam logic [CURV_W-1:0] CURV_MAX = {CURV_W{1'b1}};

  // Operation codes and register indexes.
  localparam logic        OP_LOAD           = 1'b0;
  localparam logic        OP_EVAL           = 1'b1;
  localparam int unsigned REG_SEGMENT_COUNT = 0;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_EVAL = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // Classified command word passed from the front end to the back end.
  typedef struct packed {
    kind_e                     kind;
    logic                      wr;
    logic [SEG_W-1:0]          seg;
    logic [SLOT_W-1:0]         slot;
    logic signed [PORT_W-1:0]  x;
    logic signed [PORT_W-1:0]  y;
    logic [CNT_W-1:0]          idx;
    logic [S_W-1:0]            t;
  } cmd_t;

  typedef struct packed {
    kind_e                     kind;
    logic signed [PORT_W-1:0]  pos_x;
    logic signed [PORT_W-1:0]  pos_y;
    logic signed [PORT_W-1:0]  tan_x;
    logic signed [PORT_W-1:0]  tan_y;
  } res_t;

  typedef struct packed {
    res_t                      res;
    logic signed [PORT_W-1:0]  d2x;
    logic signed [PORT_W-1:0]  d2y;
  } geo_t;

  typedef struct packed {
    res_t              res;
    logic [SQ_W-1:0]   c;
    logic [SQ_W-1:0]   m2;
    logic [SQ_W-1:0]   v;
    logic [SQ_W-1:0]   r;
  } root_t;

  typedef struct packed {
    res_t               res;
    logic [DEN_W-1:0]   den;
    logic [REM_W-1:0]   rem;
    logic [CURV_W-1:0]  quo;
    logic               fixed;
    logic [CURV_W-1:0]  fix_val;
  } div_t;

endpackage

// ----- src/pcbe_front.sv -----
// Front end: takes a command word and classifies it, finding segment and local t.
module pcbe_front #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic                                     start_i,
  input  logic                                     busy_i,
  input  logic                                     operation_i,
  input  logic [pcbe_pkg::SEG_W-1:0]               segment_index_i,
  input  logic [pcbe_pkg::SLOT_W-1:0]              point_slot_i,
  input  logic signed [pcbe_pkg::PORT_W-1:0]       point_x_i,
  input  logic signed [pcbe_pkg::PORT_W-1:0]       point_y_i,
  input  logic [pcbe_pkg::S_W-1:0]                 param_s_i,
  input  logic [pcbe_pkg::CNT_W-1:0]               seg_count_i,
  output logic                                     push_o,
  output pcbe_pkg::cmd_t                           cmd_o
);

  logic [pcbe_pkg::CNT_W-1:0]  n;
  logic [pcbe_pkg::PROD_W-1:0] prod;
  logic [pcbe_pkg::IR_W-1:0]   idx_raw;
  logic [pcbe_pkg::CNT_W-1:0]  idx;

  // Effective segment count: zero acts as one, large values clamp to the table.
  always_comb begin
    if (seg_count_i == '0) begin
      n = pcbe_pkg::CNT_W'(1);
    end else if (32'(seg_count_i) > 32'(MAX_SEGMENTS)) begin
      n = pcbe_pkg::CNT_W'(MAX_SEGMENTS);
    end else begin
      n = seg_count_i;
    end
  end

  // Segment is floor(s*n); the end point s = 1.0 falls into the last segment.
  assign prod    = pcbe_pkg::PROD_W'(param_s_i) * pcbe_pkg::PROD_W'(n);
  assign idx_raw = prod[pcbe_pkg::PROD_W-1:pcbe_pkg::FRAC_W];
  assign idx     = (idx_raw >= {1'b0, n}) ? n - pcbe_pkg::CNT_W'(1)
                                          : idx_raw[pcbe_pkg::CNT_W-1:0];

  // Classify the word.
  always_comb begin
    cmd_o.wr   = (operation_i == pcbe_pkg::OP_LOAD) &&
                 (32'(segment_index_i) < 32'(MAX_SEGMENTS));
    cmd_o.seg  = segment_index_i;
    cmd_o.slot = point_slot_i;
    cmd_o.x    = point_x_i;
    cmd_o.y    = point_y_i;
    cmd_o.idx  = idx;
    cmd_o.t    = pcbe_pkg::S_W'(prod - pcbe_pkg::PROD_W'({idx, {pcbe_pkg::FRAC_W{1'b0}}}));
    if (operation_i == pcbe_pkg::OP_LOAD) begin
      cmd_o.kind = pcbe_pkg::KIND_LOAD;
    end else if (32'(param_s_i) > 32'(pcbe_pkg::ONE_Q16)) begin
      cmd_o.kind = pcbe_pkg::KIND_ERR;
    end else begin
      cmd_o.kind = pcbe_pkg::KIND_EVAL;
    end
  end

  assign push_o = start_i && !busy_i;

endmodule

// ----- src/pcbe_queue.sv -----
// Two-entry command queue between the front end and the back end.
module pcbe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pcbe_pkg::cmd_t  cmd_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output pcbe_pkg::cmd_t  cmd_o
);

  localparam int unsigned DEPTH = 2;

  pcbe_pkg::cmd_t entry_q [DEPTH];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           do_pop;

  assign full_o  = (count_q == 2'(DEPTH));
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- src/pcbe_eval.sv -----
// Back end: control point table and de Casteljau pipeline for position, d1 and d2.
module pcbe_eval #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  pcbe_pkg::cmd_t  cmd_i,
  output logic            valid_o,
  output pcbe_pkg::geo_t  geo_o
);

  localparam int unsigned CW     = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int unsigned SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned QW     = CW + 2;
  localparam int unsigned MW     = QW + pcbe_pkg::S_W + 2;
  localparam int unsigned DW     = QW + 4;
  localparam logic signed [DW-1:0] SAT_HI = {{(DW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_LO = {{(DW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  // Difference times t, the first half of one interpolation step.
  function automatic logic signed [MW-1:0] lmul(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b,
                                                input logic [pcbe_pkg::S_W-1:0] t);
    logic signed [QW:0]             diff;
    logic signed [pcbe_pkg::S_W:0]  ts;
    diff = (QW+1)'(b) - (QW+1)'(a);
    ts   = $signed({1'b0, t});
    return MW'(diff) * MW'(ts);
  endfunction

  // Round half up to Q16 and add to the start point.
  function automatic logic signed [QW-1:0] rnd_add(input logic signed [QW-1:0] a,
                                                   input logic signed [MW-1:0] m);
    logic signed [MW:0] y;
    y = (MW+1)'(m) + (MW+1)'(pcbe_pkg::HALF_LSB);
    return a + QW'(y >>> pcbe_pkg::FRAC_W);
  endfunction

  // Saturate to signed CW bits, then widen to the port width.
  function automatic logic signed [pcbe_pkg::PORT_W-1:0] sat(input logic signed [DW-1:0] v);
    logic signed [CW-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      c = SAT_LO[CW-1:0];
    end else begin
      c = v[CW-1:0];
    end
    return pcbe_pkg::PORT_W'(c);
  endfunction

  // Control point table, one bank per slot so that all points of a segment are read together.
  logic [2*CW-1:0]   bank_mem [pcbe_pkg::NPTS][MAX_SEGMENTS];
  logic [2*CW-1:0]   rd_q     [pcbe_pkg::NPTS];
  logic              wr_en;
  logic [SEG_AW-1:0] wr_addr;
  logic [SEG_AW-1:0] rd_addr;

  assign wr_en   = valid_i && (cmd_i.kind == pcbe_pkg::KIND_LOAD) && cmd_i.wr;
  assign wr_addr = SEG_AW'(cmd_i.seg);
  assign rd_addr = SEG_AW'(cmd_i.idx);

  for (genvar k = 0; k < pcbe_pkg::NPTS; k++) begin : g_bank
    always_ff @(posedge clk_i) begin
      if (wr_en && (cmd_i.slot == pcbe_pkg::SLOT_W'(k))) begin
        bank_mem[k][wr_addr] <= {cmd_i.y[CW-1:0], cmd_i.x[CW-1:0]};
      end
      rd_q[k] <= bank_mem[k][rd_addr];
    end
  end

  // Stage valid bits and item kinds.
  logic [7:1]                 v_q;
  pcbe_pkg::kind_e            kind_q [7:1];
  logic [pcbe_pkg::S_W-1:0]   t_q    [5:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[6:1], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q[1] <= cmd_i.kind;
    t_q[1]    <= cmd_i.t;
    for (int s = 2; s <= 7; s++) begin
      kind_q[s] <= kind_q[s-1];
    end
    for (int s = 2; s <= 5; s++) begin
      t_q[s] <= t_q[s-1];
    end
  end

  // Axis 0 is x, axis 1 is y.
  logic signed [QW-1:0] p1     [2][pcbe_pkg::NPTS];
  logic signed [MW-1:0] m2_q   [2][3];
  logic signed [QW-1:0] p2_q   [2][3];
  logic signed [QW-1:0] q3_q   [2][3];
  logic signed [MW-1:0] mr4_q  [2][2];
  logic signed [QW-1:0] q4_q   [2][2];
  logic signed [QW-1:0] r5_q   [2][2];
  logic signed [MW-1:0] mp6_q  [2];
  logic signed [QW-1:0] r6_q   [2];
  logic signed [pcbe_pkg::PORT_W-1:0] d2_4_q [2];
  logic signed [pcbe_pkg::PORT_W-1:0] d2_5_q [2];
  logic signed [pcbe_pkg::PORT_W-1:0] d2_6_q [2];
  logic signed [pcbe_pkg::PORT_W-1:0] d2_7_q [2];
  logic signed [pcbe_pkg::PORT_W-1:0] d1_6_q [2];
  logic signed [pcbe_pkg::PORT_W-1:0] d1_7_q [2];
  logic signed [pcbe_pkg::PORT_W-1:0] pos7_q [2];

  // Sign-extend the stored coordinates.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < pcbe_pkg::NPTS; k++) begin
        p1[a][k] = QW'($signed(rd_q[k][a*CW +: CW]));
      end
    end
  end

  // Datapath stages: products and roundings alternate so each multiply is registered.
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 3; k++) begin
        m2_q[a][k] <= lmul(p1[a][k], p1[a][k+1], t_q[1]);
        p2_q[a][k] <= p1[a][k];
        q3_q[a][k] <= rnd_add(p2_q[a][k], m2_q[a][k]);
      end
      for (int j = 0; j < 2; j++) begin
        mr4_q[a][j] <= lmul(q3_q[a][j], q3_q[a][j+1], t_q[3]);
        q4_q[a][j]  <= q3_q[a][j];
        r5_q[a][j]  <= rnd_add(q4_q[a][j], mr4_q[a][j]);
      end
      d2_4_q[a] <= sat(DW'(pcbe_pkg::D2_GAIN) *
                       (DW'(q3_q[a][0]) - (DW'(q3_q[a][1]) <<< 1) + DW'(q3_q[a][2])));
      d2_5_q[a] <= d2_4_q[a];
      mp6_q[a]  <= lmul(r5_q[a][0], r5_q[a][1], t_q[5]);
      r6_q[a]   <= r5_q[a][0];
      d1_6_q[a] <= sat(DW'(pcbe_pkg::D1_GAIN) * (DW'(r5_q[a][1]) - DW'(r5_q[a][0])));
      d2_6_q[a] <= d2_5_q[a];
      pos7_q[a] <= sat(DW'(rnd_add(r6_q[a], mp6_q[a])));
      d1_7_q[a] <= d1_6_q[a];
      d2_7_q[a] <= d2_6_q[a];
    end
  end

  assign valid_o           = v_q[7];
  assign geo_o.res.kind    = kind_q[7];
  assign geo_o.res.pos_x   = pos7_q[0];
  assign geo_o.res.pos_y   = pos7_q[1];
  assign geo_o.res.tan_x   = d1_7_q[0];
  assign geo_o.res.tan_y   = d1_7_q[1];
  assign geo_o.d2x         = d2_7_q[0];
  assign geo_o.d2y         = d2_7_q[1];

endmodule

// ----- src/pcbe_curv.sv -----
// Curvature pipeline: cross product, square root, denominator and long division.
module pcbe_curv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  pcbe_pkg::geo_t                      geo_i,
  output logic                                done_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  pos_x_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  pos_y_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  tan_x_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  tan_y_o,
  output logic [pcbe_pkg::CURV_W-1:0]         curvature_value_o,
  output logic                                range_error_o
);

  localparam int unsigned RS = pcbe_pkg::ROOT_STEPS;
  localparam int unsigned QB = pcbe_pkg::QUO_BITS;

  // Products of d1 and d2.
  logic                          v1_q;
  pcbe_pkg::res_t                res1_q;
  logic signed [pcbe_pkg::SQ_W-1:0] cr_a_q, cr_b_q, sq_x_q, sq_y_q;

  always_ff @(posedge clk_i) begin
    res1_q <= geo_i.res;
    cr_a_q <= geo_i.res.tan_x * geo_i.d2y;
    cr_b_q <= geo_i.res.tan_y * geo_i.d2x;
    sq_x_q <= geo_i.res.tan_x * geo_i.res.tan_x;
    sq_y_q <= geo_i.res.tan_y * geo_i.res.tan_y;
  end

  // Integer square root of |d1|^2, one result bit per stage.
  logic [RS:0]     rv_q;
  pcbe_pkg::root_t root_q [RS+1];

  always_ff @(posedge clk_i) begin
    root_q[0].res <= res1_q;
    root_q[0].c   <= (cr_a_q >= cr_b_q) ? pcbe_pkg::SQ_W'(cr_a_q - cr_b_q)
                                        : pcbe_pkg::SQ_W'(cr_b_q - cr_a_q);
    root_q[0].m2  <= pcbe_pkg::SQ_W'(sq_x_q) + pcbe_pkg::SQ_W'(sq_y_q);
    root_q[0].v   <= pcbe_pkg::SQ_W'(sq_x_q) + pcbe_pkg::SQ_W'(sq_y_q);
    root_q[0].r   <= '0;
  end

  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam logic [pcbe_pkg::SQ_W-1:0] BIT = pcbe_pkg::SQ_W'(1) << (pcbe_pkg::SQ_W-2-2*k);
    logic [pcbe_pkg::SQ_W-1:0] trial;
    assign trial = root_q[k].r + BIT;
    always_ff @(posedge clk_i) begin
      root_q[k+1].res <= root_q[k].res;
      root_q[k+1].c   <= root_q[k].c;
      root_q[k+1].m2  <= root_q[k].m2;
      if (root_q[k].v >= trial) begin
        root_q[k+1].v <= root_q[k].v - trial;
        root_q[k+1].r <= (root_q[k].r >> 1) + BIT;
      end else begin
        root_q[k+1].v <= root_q[k].v;
        root_q[k+1].r <= root_q[k].r >> 1;
      end
    end
  end

  // Denominator |d1|^2 * isqrt, as two 32-bit partial products then a sum.
  logic [pcbe_pkg::ROOT_W-1:0]   m;
  logic                          vp_q, vd_q;
  pcbe_pkg::res_t                resp_q, resd_q;
  logic [pcbe_pkg::SQ_W-1:0]     cp_q, cd_q, lo_q, hi_q;
  logic [pcbe_pkg::DEN_W-1:0]    den_q;
  logic [pcbe_pkg::DEN_W-1:0]    num;

  assign m = root_q[RS].r[pcbe_pkg::ROOT_W-1:0];

  always_ff @(posedge clk_i) begin
    resp_q <= root_q[RS].res;
    cp_q   <= root_q[RS].c;
    lo_q   <= pcbe_pkg::SQ_W'(root_q[RS].m2[31:0]) * pcbe_pkg::SQ_W'(m);
    hi_q   <= pcbe_pkg::SQ_W'(root_q[RS].m2[63:32]) * pcbe_pkg::SQ_W'(m);
    resd_q <= resp_q;
    cd_q   <= cp_q;
    den_q  <= (pcbe_pkg::DEN_W'(hi_q) << 32) + pcbe_pkg::DEN_W'(lo_q);
  end

  // Division setup: zero tangent and overflow give a fixed result.
  logic [QB:0]    dv_q;
  pcbe_pkg::div_t div_q [QB+1];

  assign num = {cd_q, 32'd0};

  always_ff @(posedge clk_i) begin
    div_q[0].res <= resd_q;
    div_q[0].den <= den_q;
    div_q[0].rem <= pcbe_pkg::REM_W'(num);
    div_q[0].quo <= '0;
    if (den_q == '0) begin
      div_q[0].fixed   <= 1'b1;
      div_q[0].fix_val <= (cd_q == '0) ? '0 : pcbe_pkg::CURV_MAX;
    end else if (pcbe_pkg::REM_W'(num) >= (pcbe_pkg::REM_W'(den_q) << QB)) begin
      div_q[0].fixed   <= 1'b1;
      div_q[0].fix_val <= pcbe_pkg::CURV_MAX;
    end else begin
      div_q[0].fixed   <= 1'b0;
      div_q[0].fix_val <= '0;
    end
  end

  // Restoring division, one quotient bit per stage from the top down.
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int unsigned SH = QB - 1 - j;
    logic [pcbe_pkg::REM_W-1:0] step;
    assign step = pcbe_pkg::REM_W'(div_q[j].den) << SH;
    always_ff @(posedge clk_i) begin
      div_q[j+1].res     <= div_q[j].res;
      div_q[j+1].den     <= div_q[j].den;
      div_q[j+1].fixed   <= div_q[j].fixed;
      div_q[j+1].fix_val <= div_q[j].fix_val;
      if (!div_q[j].fixed && (div_q[j].rem >= step)) begin
        div_q[j+1].rem     <= div_q[j].rem - step;
        div_q[j+1].quo     <= div_q[j].quo | (pcbe_pkg::CURV_W'(1) << SH);
      end else begin
        div_q[j+1].rem     <= div_q[j].rem;
        div_q[j+1].quo     <= div_q[j].quo;
      end
    end
  end

  // Valid bits along the whole pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      rv_q   <= '0;
      vp_q   <= 1'b0;
      vd_q   <= 1'b0;
      dv_q   <= '0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      rv_q   <= {rv_q[RS-1:0], v1_q};
      vp_q   <= rv_q[RS];
      vd_q   <= vp_q;
      dv_q   <= {dv_q[QB-1:0], vd_q};
      done_o <= dv_q[QB];
    end
  end

  // Result register: only evaluate words carry values.
  always_ff @(posedge clk_i) begin
    range_error_o <= (div_q[QB].res.kind == pcbe_pkg::KIND_ERR);
    if (div_q[QB].res.kind == pcbe_pkg::KIND_EVAL) begin
      pos_x_o           <= div_q[QB].res.pos_x;
      pos_y_o           <= div_q[QB].res.pos_y;
      tan_x_o           <= div_q[QB].res.tan_x;
      tan_y_o           <= div_q[QB].res.tan_y;
      curvature_value_o <= div_q[QB].fixed ? div_q[QB].fix_val : div_q[QB].quo;
    end else begin
      pos_x_o           <= '0;
      pos_y_o           <= '0;
      tan_x_o           <= '0;
      tan_y_o           <= '0;
      curvature_value_o <= '0;
    end
  end

endmodule

// ----- src/piecewise_cubic_bezier_eval.sv -----
// Top level of the piecewise cubic Bezier evaluator with configuration port.
//
// Usage:
// A command word is taken at a rising edge where start_i is high and busy_o is
// low. operation_i selects a control point load or an evaluation at param_s_i.
// Every word gives exactly one result word, shown on the result ports for one
// cycle with done_o high; loads return all zeros, and a parameter above 1.0
// returns range_error_o with all other fields zero.
// Results pass the interpolation stages and then the curvature path: 32 square
// root stages, the two-step denominator product and 31 division stages.
// Throughput is one word per cycle; the queue between front and back end
// drains every cycle, so busy_o stays low in normal use.
// segment_count is written through the APB port at byte address 0 and resets
// to 1. Reset clears the pipeline and the queue; the control point table is
// not cleared and holds undefined data until loaded.
// The receiver cannot stall: a result must be taken in the cycle it appears.
module piecewise_cubic_bezier_eval #(
  parameter int unsigned MAX_SEGMENTS = 16,
  parameter int unsigned COORD_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [2:0]                          paddr_i,
  input  logic [31:0]                         pwdata_i,
  output logic [31:0]                         prdata_o,
  output logic                                pready_o,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                operation_i,
  input  logic [pcbe_pkg::SEG_W-1:0]          segment_index_i,
  input  logic [pcbe_pkg::SLOT_W-1:0]         point_slot_i,
  input  logic signed [pcbe_pkg::PORT_W-1:0]  point_x_i,
  input  logic signed [pcbe_pkg::PORT_W-1:0]  point_y_i,
  input  logic [pcbe_pkg::S_W-1:0]            param_s_i,
  output logic                                done_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  pos_x_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  pos_y_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  tan_x_o,
  output logic signed [pcbe_pkg::PORT_W-1:0]  tan_y_o,
  output logic [pcbe_pkg::CURV_W-1:0]         curvature_value_o,
  output logic                                range_error_o
);

  logic [pcbe_pkg::CNT_W-1:0] seg_count_q;
  logic                       reg_hit;
  logic                       push;
  logic                       q_valid;
  pcbe_pkg::cmd_t             front_cmd;
  pcbe_pkg::cmd_t             back_cmd;
  logic                       geo_valid;
  pcbe_pkg::geo_t             geo;

  // Configuration register.
  assign pready_o = 1'b1;
  assign reg_hit  = ({29'd0, paddr_i[2]} == 30'(pcbe_pkg::REG_SEGMENT_COUNT));
  assign prdata_o = reg_hit ? 32'(seg_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= pcbe_pkg::CNT_W'(1);
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_hit) begin
      seg_count_q <= pwdata_i[pcbe_pkg::CNT_W-1:0];
    end
  end

  pcbe_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .start_i         (start_i),
    .busy_i          (busy_o),
    .operation_i     (operation_i),
    .segment_index_i (segment_index_i),
    .point_slot_i    (point_slot_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .param_s_i       (param_s_i),
    .seg_count_i     (seg_count_q),
    .push_o          (push),
    .cmd_o           (front_cmd)
  );

  pcbe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (q_valid),
    .full_o  (busy_o),
    .valid_o (q_valid),
    .cmd_o   (back_cmd)
  );

  pcbe_eval #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (back_cmd),
    .valid_o (geo_valid),
    .geo_o   (geo)
  );

  pcbe_curv u_curv (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (geo_valid),
    .geo_i             (geo),
    .done_o            (done_o),
    .pos_x_o           (pos_x_o),
    .pos_y_o           (pos_y_o),
    .tan_x_o           (tan_x_o),
    .tan_y_o           (tan_y_o),
    .curvature_value_o (curvature_value_o),
    .range_error_o     (range_error_o)
  );

`ifndef SYNTHESIS
  // Every accepted word yields its result after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##77 done_o)
    else $error("result strobe missing after accepted word");

  // The back end drains the queue every cycle, so it never fills.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("command queue filled up");

  // A range error result carries no position, tangent or curvature.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && range_error_o) |-> (pos_x_o == '0 && pos_y_o == '0 &&
      tan_x_o == '0 && tan_y_o == '0 && curvature_value_o == '0))
    else $error("range error result with nonzero fields");
`endif

endmodule

// ----- test/piecewise_cubic_bezier_eval_test.sv -----
// Self-checking testbench for the piecewise cubic Bezier evaluator.
`timescale 1ns / 100ps

module piecewise_cubic_bezier_eval_test;

  localparam int unsigned NSEG = 16;
  localparam int unsigned LATENCY = 77;
  localparam logic [pcbe_pkg::PORT_W-1:0] S_MAX = 32'h7fff_ffff;
  localparam logic [pcbe_pkg::PORT_W-1:0] S_MIN = 32'h8000_0000;

  typedef struct {
    logic                        op;
    logic [pcbe_pkg::SEG_W-1:0]  seg;
    logic [pcbe_pkg::SLOT_W-1:0] slot;
    logic [31:0]                 x;
    logic [31:0]                 y;
    logic [pcbe_pkg::S_W-1:0]    s;
  } word_t;

  typedef struct {
    logic [31:0]                 pos_x;
    logic [31:0]                 pos_y;
    logic [31:0]                 tan_x;
    logic [31:0]                 tan_y;
    logic [pcbe_pkg::CURV_W-1:0] curv;
    logic                        err;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel_i = 1'b0, penable_i = 1'b0, pwrite_i = 1'b0;
  logic [2:0] paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic pready_o;
  logic start_i = 1'b0;
  logic busy_o;
  logic operation_i = pcbe_pkg::OP_LOAD;
  logic [pcbe_pkg::SEG_W-1:0] segment_index_i = '0;
  logic [pcbe_pkg::SLOT_W-1:0] point_slot_i = '0;
  logic signed [pcbe_pkg::PORT_W-1:0] point_x_i = '0;
  logic signed [pcbe_pkg::PORT_W-1:0] point_y_i = '0;
  logic [pcbe_pkg::S_W-1:0] param_s_i = '0;
  logic done_o;
  logic signed [pcbe_pkg::PORT_W-1:0] pos_x_o, pos_y_o, tan_x_o, tan_y_o;
  logic [pcbe_pkg::CURV_W-1:0] curvature_value_o;
  logic range_error_o;

  piecewise_cubic_bezier_eval dut (.*);

  always #4 clk_i = ~clk_i;

  // Shadow of the control point table and the segment count.
  longint ctrl_x [4*NSEG];
  longint ctrl_y [4*NSEG];
  logic [pcbe_pkg::CNT_W-1:0] seg_count = 5'd1;

  word_t  pending_words[$];
  point_t expected_points[$];
  word_t  shown_word;
  int     idle_pct = 0;
  bit     hold_off = 1'b0;
  int     fails = 0;

  function automatic longint round16(longint v);
    return (v + pcbe_pkg::HALF_LSB) >>> 16;
  endfunction

  function automatic longint lerp16(longint a, longint b, longint t);
    return a + round16((b - a) * t);
  endfunction

  function automatic longint sat32(longint v);
    if (v > longint'(S_MAX)) return longint'(S_MAX);
    if (v < -longint'(S_MAX) - 1) return -longint'(S_MAX) - 1;
    return v;
  endfunction

  // Curvature |a x b| / |a|^3 in unsigned Q15.16, saturated, with the zero tangent cases.
  function automatic logic [pcbe_pkg::CURV_W-1:0] curvature_of(longint ax, longint ay,
                                                               longint bx, longint by);
    longint p, q;
    logic [63:0] c, m2, v, r, b;
    logic [127:0] den, quo;
    p = ax * by;
    q = ay * bx;
    c = (p >= q) ? 64'(p - q) : 64'(q - p);
    m2 = 64'(ax * ax) + 64'(ay * ay);
    v = m2;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    den = {64'd0, m2} * {64'd0, r};
    if (den == 0) return (c == 0) ? '0 : pcbe_pkg::CURV_MAX;
    quo = ({64'd0, c} << 32) / den;
    if (quo > {97'd0, pcbe_pkg::CURV_MAX}) return pcbe_pkg::CURV_MAX;
    return quo[pcbe_pkg::CURV_W-1:0];
  endfunction

  // Expected result of one accepted word; loads update the shadow table.
  function automatic point_t bezier_point(word_t w);
    point_t res;
    longint px[4], py[4], qx[3], qy[3], r0x, r0y, r1x, r1y, t, d1x, d1y, d2x, d2y;
    int n, idx;
    res = '{default: '0};
    if (w.op == pcbe_pkg::OP_LOAD) begin
      ctrl_x[w.seg*4 + w.slot] = longint'(signed'(w.x));
      ctrl_y[w.seg*4 + w.slot] = longint'(signed'(w.y));
      return res;
    end
    if (w.s > pcbe_pkg::ONE_Q16) begin
      res.err = 1'b1;
      return res;
    end
    n = (seg_count == 0) ? 1 : (seg_count > NSEG ? NSEG : seg_count);
    idx = (int'(w.s) * n) >> 16;
    if (idx >= n) idx = n - 1;
    t = longint'(w.s) * n - (longint'(idx) << 16);
    for (int k = 0; k < 4; k++) begin
      px[k] = ctrl_x[idx*4 + k];
      py[k] = ctrl_y[idx*4 + k];
    end
    for (int k = 0; k < 3; k++) begin
      qx[k] = lerp16(px[k], px[k+1], t);
      qy[k] = lerp16(py[k], py[k+1], t);
    end
    r0x = lerp16(qx[0], qx[1], t);
    r0y = lerp16(qy[0], qy[1], t);
    r1x = lerp16(qx[1], qx[2], t);
    r1y = lerp16(qy[1], qy[2], t);
    res.pos_x = 32'(sat32(lerp16(r0x, r1x, t)));
    res.pos_y = 32'(sat32(lerp16(r0y, r1y, t)));
    d1x = sat32(pcbe_pkg::D1_GAIN * (r1x - r0x));
    d1y = sat32(pcbe_pkg::D1_GAIN * (r1y - r0y));
    d2x = sat32(pcbe_pkg::D2_GAIN * (qx[0] - 2 * qx[1] + qx[2]));
    d2y = sat32(pcbe_pkg::D2_GAIN * (qy[0] - 2 * qy[1] + qy[2]));
    res.tan_x = 32'(d1x);
    res.tan_y = 32'(d1y);
    res.curv = curvature_of(d1x, d1y, d2x, d2y);
    return res;
  endfunction

  // Driver: predict each accepted word, then present the next one or idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) expected_points.push_back(bezier_point(shown_word));
      if (!(start_i && busy_o)) begin
        if (!hold_off && pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          shown_word = pending_words.pop_front();
          start_i <= 1'b1;
          operation_i <= shown_word.op;
          segment_index_i <= shown_word.seg;
          point_slot_i <= shown_word.slot;
          point_x_i <= shown_word.x;
          point_y_i <= shown_word.y;
          param_s_i <= shown_word.s;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result word is checked against the oldest expectation.
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = expected_points.pop_front();
        if (pos_x_o !== e.pos_x) begin
          $error("pos_x expected %h got %h", e.pos_x, pos_x_o); fails++;
        end
        if (pos_y_o !== e.pos_y) begin
          $error("pos_y expected %h got %h", e.pos_y, pos_y_o); fails++;
        end
        if (tan_x_o !== e.tan_x) begin
          $error("tan_x expected %h got %h", e.tan_x, tan_x_o); fails++;
        end
        if (tan_y_o !== e.tan_y) begin
          $error("tan_y expected %h got %h", e.tan_y, tan_y_o); fails++;
        end
        if (curvature_value_o !== e.curv) begin
          $error("curvature_value expected %h got %h", e.curv, curvature_value_o); fails++;
        end
        if (range_error_o !== e.err) begin
          $error("range_error expected %b got %b", e.err, range_error_o); fails++;
        end
      end
    end
  end

  task automatic push_load(int seg, int slot, logic [31:0] x, logic [31:0] y);
    word_t w;
    w = '{op: pcbe_pkg::OP_LOAD, seg: pcbe_pkg::SEG_W'(seg),
          slot: pcbe_pkg::SLOT_W'(slot), x: x, y: y, s: pcbe_pkg::S_W'($urandom)};
    pending_words.push_back(w);
  endtask

  task automatic push_eval(logic [pcbe_pkg::S_W-1:0] s);
    word_t w;
    w = '{op: pcbe_pkg::OP_EVAL, seg: pcbe_pkg::SEG_W'($urandom),
          slot: pcbe_pkg::SLOT_W'($urandom), x: $urandom, y: $urandom, s: s};
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom;
    return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
  endfunction

  // Mostly in-range evaluations with random loads and some out-of-range parameters.
  task automatic push_random(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        push_load($urandom_range(NSEG-1), $urandom_range(3), rand_coord(), rand_coord());
      end else if (pick < 28) begin
        push_eval(pcbe_pkg::S_W'($urandom_range(131071, pcbe_pkg::ONE_Q16 + 1)));
      end else if (pick < 32) begin
        push_eval(pcbe_pkg::S_W'($urandom_range(1) ? pcbe_pkg::ONE_Q16 : 0));
      end else begin
        push_eval(pcbe_pkg::S_W'($urandom_range(pcbe_pkg::ONE_Q16)));
      end
    end
  endtask

  // Waits until every word is out and answered, then for the pipeline depth.
  task automatic drain();
    while (pending_words.size() > 0 || start_i || expected_points.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_count(logic [31:0] value);
    @(posedge clk_i);
    psel_i <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i <= 1'b1;
    paddr_i <= 3'(4 * pcbe_pkg::REG_SEGMENT_COUNT);
    pwdata_i <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    while (!pready_o) @(posedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    seg_count = value[pcbe_pkg::CNT_W-1:0];
  endtask

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int counts[5];
    int pcts[5];
    counts = '{16, 0, 31, 5, 16};
    pcts = '{0, 52, 0, 34, 52};
    for (int i = 0; i < 4*NSEG; i++) begin
      ctrl_x[i] = 0;
      ctrl_y[i] = 0;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    write_count(1);

    // Directed: extreme points, parameter edges, and a flat segment.
    push_load(0, 0, S_MIN, S_MAX);
    push_load(0, 1, S_MAX, S_MIN);
    push_load(0, 2, S_MIN, S_MIN);
    push_load(0, 3, S_MAX, S_MAX);
    push_eval(pcbe_pkg::S_W'(0));
    push_eval(pcbe_pkg::S_W'(1));
    push_eval(pcbe_pkg::S_W'(16'h8000));
    push_eval(pcbe_pkg::S_W'(pcbe_pkg::ONE_Q16 - 1));
    push_eval(pcbe_pkg::S_W'(pcbe_pkg::ONE_Q16));
    push_eval(pcbe_pkg::S_W'(pcbe_pkg::ONE_Q16 + 1));
    push_eval(17'h1ffff);
    for (int k = 0; k < 4; k++) push_load(0, k, 32'h0001_0000, 32'hffff_0000);
    push_eval(pcbe_pkg::S_W'(16'h4000));
    // Zero tangent with a bend: the cross product is zero, so curvature is zero.
    push_load(0, 0, 0, 0);
    push_load(0, 1, 0, 0);
    push_load(0, 2, 32'h0001_0000, 32'h0002_0000);
    push_load(0, 3, 32'h0003_0000, 0);
    push_eval(pcbe_pkg::S_W'(0));
    push_eval(pcbe_pkg::S_W'(16'h6000));
    drain();

    // Fill the whole table before counts above one are used.
    for (int i = 0; i < 4*NSEG; i++) push_load(i / 4, i % 4, rand_coord(), rand_coord());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_count(counts[ph]);
      idle_pct = pcts[ph];
      push_random(50);
      // Sender holds off until every result is in.
      while (pending_words.size() > 0) @(posedge clk_i);
      hold_off = 1'b1;
      while (expected_points.size() > 0) @(posedge clk_i);
      @(posedge clk_i);
      hold_off = 1'b0;
      push_random(50);
      drain();
    end

    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
src/pcbe_pkg.sv
src/pcbe_front.sv
src/pcbe_queue.sv
src/pcbe_eval.sv
src/pcbe_curv.sv
src/piecewise_cubic_bezier_eval.sv
test/piecewise_cubic_bezier_eval_test.sv
